### design/oohq_pkg.sv
// shared types and constants for the oldest-or-highest-priority queue
package oohq_pkg;

	localparam int TABLE_DEPTH   = 64;
	localparam int PRIORITY_BITS = 16;
	localparam int TICKET_W      = 32;
	localparam int IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int OCC_W         = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_ARRIVE  = 2'd0,
		MODE_OLDEST  = 2'd1,
		MODE_HIGHEST = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STAT_STORED = 2'd0,
		STAT_SERVED = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_SCAN,
		ST_TAKE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [TICKET_W-1:0]      ticket;
		logic [PRIORITY_BITS-1:0] prio;
	} entry_t;

endpackage

### design/oohq_cmp.sv
// shared compare unit: is the candidate entry served before the current best
module oohq_cmp (
	input  logic            by_prio,
	input  oohq_pkg::entry_t cand,
	input  oohq_pkg::entry_t best,
	output logic            better
);
	import oohq_pkg::*;

	logic older;

	assign older = cand.ticket < best.ticket;

	always_comb begin
		if (by_prio) begin
			better = (cand.prio > best.prio) || ((cand.prio == best.prio) && older);
		end else begin
			better = older;
		end
	end

endmodule

### design/oldest_or_highest_priority_queue_core.sv
// top level: waiting table with oldest-first and highest-priority-first service
//
// input beat (s_*): s_tuser carries the request kind (arrival, serve oldest,
// serve highest priority), s_tdata the priority of an arriving entry.
// output beat (m_*): s_tuser-like m_tuser carries the status, m_tdata the
// ticket given on arrival or the ticket of the served entry (0 otherwise).
// one output beat per input beat, in order.
// rejected requests (empty, full, tickets used up, unknown kind) go straight
// to the finish state. an arrival walks the valid bits one per cycle to the
// lowest free slot. a serve walks the whole table through the single read
// port of the entry memory and the one compare unit.
// one request is in flight at a time; s_tready is high only while idle.
// a finished result sits in the output register until taken; the next request
// is accepted meanwhile, but its result waits for the register to drain.
// reset clears the valid bits, the occupancy and sets the next ticket to 1;
// the entry memory itself is not cleared.
module oldest_or_highest_priority_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] priority_req
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] ticket
	output logic [1:0]  m_tuser    // [1:0] status
);
	import oohq_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	state_t state_q, state_d;

	logic [TABLE_DEPTH-1:0]   valid_q;
	logic [OCC_W-1:0]         occ_q;
	logic [TICKET_W-1:0]      next_ticket_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     issue_q;
	logic                     by_prio_q;
	logic [PRIORITY_BITS-1:0] prio_q;

	entry_t                   mem [TABLE_DEPTH];
	entry_t                   rdata_s1;
	logic                     rd_vld_s1;
	logic                     last_s1;
	logic [IDX_W-1:0]         idx_s1;

	entry_t                   best_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic                     have_best_q;
	logic                     better;

	status_t                  res_status_q;
	logic [TICKET_W-1:0]      res_ticket_q;
	logic                     m_tvalid_q;
	logic [1:0]               m_tuser_q;
	logic [TICKET_W-1:0]      m_tdata_q;

	logic                     acc;
	logic                     start_find;
	logic                     start_scan;
	logic                     free_hit;
	logic                     out_load;
	logic                     full;
	status_t                  imm_status;
	logic [31:0]              prio_ext;
	logic                     wr_en;
	entry_t                   wdata;

	assign full     = (occ_q == OCC_W'(TABLE_DEPTH)) || (next_ticket_q == '0);
	assign prio_ext = {16'b0, s_tdata};
	assign wdata    = '{ticket: next_ticket_q, prio: prio_q};
	assign wr_en    = free_hit;

	oohq_cmp u_cmp (
		.by_prio (by_prio_q),
		.cand    (rdata_s1),
		.best    (best_q),
		.better  (better)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		acc        = 1'b0;
		start_find = 1'b0;
		start_scan = 1'b0;
		free_hit   = 1'b0;
		out_load   = 1'b0;
		imm_status = STAT_FULL;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				acc      = s_tvalid;
				unique case (s_tuser)
					MODE_ARRIVE: begin
						imm_status = STAT_FULL;
						start_find = acc && !full;
					end
					MODE_OLDEST, MODE_HIGHEST: begin
						imm_status = STAT_EMPTY;
						start_scan = acc && (occ_q != '0);
					end
					default: imm_status = STAT_FULL;
				endcase
				if (start_find) begin
					state_d = ST_FIND;
				end else if (start_scan) begin
					state_d = ST_SCAN;
				end else if (acc) begin
					state_d = ST_FINISH;
				end
			end
			ST_FIND: begin
				free_hit = !valid_q[idx_q];
				if (free_hit) begin
					state_d = ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (last_s1) begin
					state_d = ST_TAKE;
				end
			end
			ST_TAKE: state_d = ST_FINISH;
			ST_FINISH: begin
				out_load = !m_tvalid_q || m_tready;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// entry memory, one port addressed by the walk counter
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_q] <= wdata;
		end
		rdata_s1 <= mem[idx_q];
		idx_s1   <= idx_q;
	end

	// table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			occ_q         <= '0;
			next_ticket_q <= TICKET_W'(1);
			idx_q         <= '0;
			issue_q       <= 1'b0;
			rd_vld_s1     <= 1'b0;
			last_s1       <= 1'b0;
			have_best_q   <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && issue_q && valid_q[idx_q];
			last_s1   <= (state_q == ST_SCAN) && issue_q && (idx_q == LAST_IDX);
			if (start_find || start_scan) begin
				idx_q       <= '0;
				issue_q     <= start_scan;
				have_best_q <= 1'b0;
			end else if (state_q == ST_FIND) begin
				if (free_hit) begin
					valid_q[idx_q] <= 1'b1;
					occ_q          <= occ_q + OCC_W'(1);
					next_ticket_q  <= next_ticket_q + TICKET_W'(1);
				end else if (idx_q != LAST_IDX) begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end else if (state_q == ST_SCAN) begin
				if (issue_q) begin
					if (idx_q == LAST_IDX) begin
						issue_q <= 1'b0;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				if (rd_vld_s1 && (!have_best_q || better)) begin
					have_best_q <= 1'b1;
				end
			end else if (state_q == ST_TAKE) begin
				valid_q[best_idx_q] <= 1'b0;
				occ_q               <= occ_q - OCC_W'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// request, running best and result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			by_prio_q    <= (s_tuser == MODE_HIGHEST);
			prio_q       <= prio_ext[PRIORITY_BITS-1:0];
			res_status_q <= imm_status;
			res_ticket_q <= '0;
		end
		if (free_hit) begin
			res_status_q <= STAT_STORED;
			res_ticket_q <= next_ticket_q;
		end
		if ((state_q == ST_SCAN) && rd_vld_s1 && (!have_best_q || better)) begin
			best_q     <= rdata_s1;
			best_idx_q <= idx_s1;
		end
		if (state_q == ST_TAKE) begin
			res_status_q <= STAT_SERVED;
			res_ticket_q <= best_q.ticket;
		end
		if (out_load) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= res_ticket_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// occupancy tracks the valid bits
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(occ_q))
		else $error("occupancy does not match valid bits");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(TABLE_DEPTH))
		else $error("occupancy above table depth");

	// a serve only reaches removal after finding a valid entry
	a_take_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAKE) |-> have_best_q)
		else $error("serve without a selected entry");

	// a slot search only starts with room in the table
	a_find_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND) |-> (occ_q < OCC_W'(TABLE_DEPTH)))
		else $error("slot search on a full table");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result beat raised outside finish");

endmodule
